// File: src/segmented_store_manager_top_assert.svh
// Assertion macros for the segmented store manager checker.
// Both sample on the rising edge of clk and stay quiet while rst is high.
`ifndef SEGMENTED_STORE_MANAGER_TOP_ASSERT_SVH
`define SEGMENTED_STORE_MANAGER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segmented store manager: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segmented store manager: next-cycle check failed");

`endif

// File: src/ssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, codes and sizes of the segmented store manager.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int SLOTS      = 64;
  localparam int MAX_STORES = 64;
  localparam int SLOT_AW    = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ID_W       = $clog2(MAX_STORES);
  localparam int SID_W      = $clog2(MAX_STORES + 1);

  // operations
  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_ADD       = 3'd1;
  localparam logic [2:0] OP_DEL_VAL   = 3'd2;
  localparam logic [2:0] OP_DEL_POS   = 3'd3;
  localparam logic [2:0] OP_DEL_STORE = 3'd4;
  localparam logic [2:0] OP_RESIZE    = 3'd5;

  // result status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  // slot index register update
  localparam logic [2:0] IDX_HOLD    = 3'd0;
  localparam logic [2:0] IDX_ZERO    = 3'd1;
  localparam logic [2:0] IDX_INC     = 3'd2;
  localparam logic [2:0] IDX_DEC     = 3'd3;
  localparam logic [2:0] IDX_BASE    = 3'd4;
  localparam logic [2:0] IDX_END     = 3'd5;
  localparam logic [2:0] IDX_BASE_SZ = 3'd6;

  // free count update
  localparam logic [1:0] FREE_HOLD     = 2'd0;
  localparam logic [1:0] FREE_ADD_CAP  = 2'd1;
  localparam logic [1:0] FREE_ADD_SHR  = 2'd2;
  localparam logic [1:0] FREE_SUB_GROW = 2'd3;

  // slot read address
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_UP   = 2'd1;
  localparam logic [1:0] RD_DOWN = 2'd2;

  // slot write source
  localparam logic [1:0] WR_POS_VAL = 2'd0;
  localparam logic [1:0] WR_IDX_VAL = 2'd1;
  localparam logic [1:0] WR_IDX_RD  = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         store_id;
    logic signed [31:0] element_value;
    logic [5:0]         position;
    logic               use_position;
    logic [6:0]         size;
  } ssm_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] result_store_id;
    logic [6:0] free_slots;
  } ssm_out_t;

  typedef struct packed {
    logic       load_req;
    logic       do_create;
    logic       set_st;
    logic [2:0] st;
    logic [2:0] idx_sel;
    logic       base_clr;
    logic       base_acc;
    logic       size_rd;
    logic       cap_load;
    logic       size_wr;
    logic       size_zero;
    logic [1:0] free_sel;
    logic       sh_load;
    logic       sh_shrink;
    logic       slot_rd;
    logic [1:0] rd_sel;
    logic       slot_wr;
    logic [1:0] wr_sel;
    logic       slot_clr;
    logic       clr_pos;
    logic       clr_range;
    logic       out_load;
  } ssm_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       use_pos;
    logic       id_unknown;
    logic       create_fail;
    logic       pos_bad;
    logic       grow;
    logic       shrink;
    logic       grow_fail;
    logic       top_fits;
    logic       cap_zero;
    logic       base_done;
    logic       scan_more;
    logic       rd_empty;
    logic       rd_match;
    logic       shift_in;
    logic       last;
    logic       grow_more;
    logic       out_free;
  } ssm_flags_t;

endpackage

// File: src/ssm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_dp
// Datapath: slot memory, store size memory, counters and result register.
// ----------------------------------------------------------------------------
module ssm_dp (
  input  logic               clk,
  input  logic               rst,
  input  ssm_pkg::ssm_in_t   in_word,
  input  ssm_pkg::ssm_cmd_t  cmd,
  output ssm_pkg::ssm_flags_t flags,
  input  logic               out_stall,
  output logic               out_valid,
  output ssm_pkg::ssm_out_t  out_word
);
  import ssm_pkg::*;

  logic [31:0]        mem [SLOTS];
  logic [SLOTS-1:0]   vld;
  logic [CNT_W-1:0]   sizes [MAX_STORES];

  ssm_in_t            req;
  logic [CNT_W-1:0]   base, cap, idx, sh, free_count, size_q;
  logic [SID_W-1:0]   stores_made;
  logic [2:0]         st;
  logic [ID_W-1:0]    newid;
  logic [31:0]        rdata, rd_val, wdata;
  logic               rvld;

  logic [CNT_W:0]     end_k, top, pos_abs, up_abs, hi;
  logic [CNT_W-1:0]   grow_amt, shr_amt, down_abs;
  logic [SLOT_AW-1:0] raddr, waddr, caddr;
  logic [ID_W-1:0]    saddr;
  logic [CNT_W-1:0]   sdata;

  assign end_k    = {1'b0, base} + {1'b0, cap};
  assign top      = {1'b0, base} + {1'b0, req.size};
  assign pos_abs  = {1'b0, base} + (CNT_W+1)'(req.position);
  assign up_abs   = {1'b0, idx} + {1'b0, sh};
  assign grow_amt = req.size - cap;
  assign shr_amt  = cap - req.size;
  assign down_abs = idx - grow_amt;
  assign rd_val   = rvld ? rdata : '0;
  assign hi       = (top > (CNT_W+1)'(SLOTS)) ? (CNT_W+1)'(SLOTS) : top;

  always_comb begin
    case (cmd.rd_sel)
      RD_UP:   raddr = up_abs[SLOT_AW-1:0];
      RD_DOWN: raddr = down_abs[SLOT_AW-1:0];
      default: raddr = idx[SLOT_AW-1:0];
    endcase
    case (cmd.wr_sel)
      WR_POS_VAL: begin
        waddr = pos_abs[SLOT_AW-1:0];
        wdata = req.element_value;
      end
      WR_IDX_RD: begin
        waddr = idx[SLOT_AW-1:0];
        wdata = rd_val;
      end
      default: begin
        waddr = idx[SLOT_AW-1:0];
        wdata = req.element_value;
      end
    endcase
    caddr = cmd.clr_pos ? pos_abs[SLOT_AW-1:0] : idx[SLOT_AW-1:0];
    saddr = cmd.do_create ? stores_made[ID_W-1:0] : req.store_id;
    sdata = cmd.size_zero ? '0 : req.size;
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.slot_wr) begin
      mem[waddr] <= wdata;
    end
    if (cmd.slot_rd) begin
      rdata <= mem[raddr];
      rvld  <= vld[raddr];
    end
  end

  // valid bits: a slot never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (cmd.slot_wr) begin
        vld[waddr] <= 1'b1;
      end
      if (cmd.slot_clr) begin
        vld[caddr] <= 1'b0;
      end
      if (cmd.clr_range) begin
        for (int i = 0; i < SLOTS; i++) begin
          if ((CNT_W+1)'(i) >= end_k && (CNT_W+1)'(i) < hi) begin
            vld[i] <= 1'b0;
          end
        end
      end
    end
  end

  // store size memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.do_create || cmd.size_wr) begin
      sizes[saddr] <= sdata;
    end
    if (cmd.size_rd) begin
      size_q <= sizes[idx[ID_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_word;
    end
    if (cmd.base_clr) begin
      base <= '0;
    end else if (cmd.base_acc) begin
      base <= base + size_q;
    end
    if (cmd.cap_load) begin
      cap <= size_q;
    end
    if (cmd.sh_load) begin
      sh <= cmd.sh_shrink ? shr_amt : cap;
    end
    case (cmd.idx_sel)
      IDX_ZERO:    idx <= '0;
      IDX_INC:     idx <= idx + 1'b1;
      IDX_DEC:     idx <= idx - 1'b1;
      IDX_BASE:    idx <= base;
      IDX_END:     idx <= CNT_W'(SLOTS - 1);
      IDX_BASE_SZ: idx <= top[CNT_W-1:0];
      default:     idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count  <= CNT_W'(SLOTS);
      stores_made <= '0;
      st          <= ST_OK;
      newid       <= '0;
    end else begin
      if (cmd.load_req) begin
        st    <= ST_OK;
        newid <= '0;
      end else if (cmd.set_st) begin
        st <= cmd.st;
      end
      if (cmd.do_create) begin
        newid       <= stores_made[ID_W-1:0];
        stores_made <= stores_made + 1'b1;
        free_count  <= free_count - req.size;
      end else begin
        case (cmd.free_sel)
          FREE_ADD_CAP:  free_count <= free_count + cap;
          FREE_ADD_SHR:  free_count <= free_count + shr_amt;
          FREE_SUB_GROW: free_count <= free_count - grow_amt;
          default:       free_count <= free_count;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.status          <= st;
      out_word.result_store_id <= newid;
      out_word.free_slots      <= free_count;
    end
  end

  always_comb begin
    flags.op          = req.operation;
    flags.use_pos     = req.use_position;
    flags.id_unknown  = SID_W'(req.store_id) >= stores_made;
    flags.create_fail = (req.size > free_count) || (stores_made >= SID_W'(MAX_STORES));
    flags.pos_bad     = (CNT_W'(req.position) >= cap) || (pos_abs >= (CNT_W+1)'(SLOTS));
    flags.grow        = req.size > cap;
    flags.shrink      = req.size < cap;
    flags.grow_fail   = (req.size > cap) && (grow_amt > free_count);
    flags.top_fits    = top <= (CNT_W+1)'(SLOTS);
    flags.cap_zero    = cap == '0;
    flags.base_done   = idx == CNT_W'(req.store_id);
    flags.scan_more   = ({1'b0, idx} < end_k) && (idx < CNT_W'(SLOTS));
    flags.rd_empty    = rd_val == '0;
    flags.rd_match    = rd_val == $unsigned(req.element_value);
    flags.shift_in    = up_abs < (CNT_W+1)'(SLOTS);
    flags.last        = idx == CNT_W'(SLOTS - 1);
    flags.grow_more   = {1'b0, idx} >= top;
    flags.out_free    = !out_valid || !out_stall;
  end

endmodule

// File: src/ssm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_ctrl
// Controller: sequences base walk, slot scans, shifts and result hand-off.
// ----------------------------------------------------------------------------
module ssm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssm_pkg::ssm_flags_t flags,
  output ssm_pkg::ssm_cmd_t   cmd
);
  import ssm_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_BASE_RD  = 4'd2;
  localparam logic [3:0] S_BASE_ACC = 4'd3;
  localparam logic [3:0] S_CAP      = 4'd4;
  localparam logic [3:0] S_DISP     = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CHK = 4'd7;
  localparam logic [3:0] S_SHIFT_RD = 4'd8;
  localparam logic [3:0] S_SHIFT_WR = 4'd9;
  localparam logic [3:0] S_GROW_RD  = 4'd10;
  localparam logic [3:0] S_GROW_WR  = 4'd11;
  localparam logic [3:0] S_FINISH   = 4'd12;

  logic [3:0] state, state_next;

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FINISH;
        if (flags.op == OP_CREATE) begin
          if (flags.create_fail) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_NOSPACE;
          end else begin
            cmd.do_create = 1'b1;
          end
        end else if (flags.op inside {[OP_ADD:OP_RESIZE]}) begin
          if (flags.id_unknown) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_UNKNOWN;
          end else begin
            cmd.base_clr = 1'b1;
            cmd.idx_sel  = IDX_ZERO;
            state_next   = S_BASE_RD;
          end
        end
      end
      S_BASE_RD: begin
        cmd.size_rd = 1'b1;
        state_next  = flags.base_done ? S_CAP : S_BASE_ACC;
      end
      S_BASE_ACC: begin
        cmd.base_acc = 1'b1;
        cmd.idx_sel  = IDX_INC;
        state_next   = S_BASE_RD;
      end
      S_CAP: begin
        cmd.cap_load = 1'b1;
        state_next   = S_DISP;
      end
      S_DISP: begin
        state_next = S_FINISH;
        case (flags.op)
          OP_ADD: begin
            if (flags.use_pos) begin
              if (flags.pos_bad) begin
                cmd.set_st = 1'b1;
                cmd.st     = ST_RANGE;
              end else begin
                cmd.slot_wr = 1'b1;
                cmd.wr_sel  = WR_POS_VAL;
              end
            end else begin
              cmd.set_st  = 1'b1;
              cmd.st      = ST_RANGE;
              cmd.idx_sel = IDX_BASE;
              state_next  = S_SCAN_RD;
            end
          end
          OP_DEL_VAL: begin
            cmd.set_st  = 1'b1;
            cmd.st      = ST_NOTFOUND;
            cmd.idx_sel = IDX_BASE;
            state_next  = S_SCAN_RD;
          end
          OP_DEL_POS: begin
            if (flags.pos_bad) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else begin
              cmd.slot_clr = 1'b1;
              cmd.clr_pos  = 1'b1;
            end
          end
          OP_DEL_STORE: begin
            cmd.free_sel  = FREE_ADD_CAP;
            cmd.size_wr   = 1'b1;
            cmd.size_zero = 1'b1;
            if (!flags.cap_zero) begin
              cmd.sh_load = 1'b1;
              cmd.idx_sel = IDX_BASE;
              state_next  = S_SHIFT_RD;
            end
          end
          OP_RESIZE: begin
            if (flags.grow_fail) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_NOSPACE;
            end else begin
              cmd.size_wr = 1'b1;
              if (flags.shrink) begin
                cmd.free_sel  = FREE_ADD_SHR;
                cmd.sh_load   = 1'b1;
                cmd.sh_shrink = 1'b1;
                cmd.idx_sel   = IDX_BASE_SZ;
                state_next    = S_SHIFT_RD;
              end else if (flags.grow) begin
                cmd.free_sel = FREE_SUB_GROW;
                if (flags.top_fits) begin
                  cmd.idx_sel = IDX_END;
                  state_next  = S_GROW_RD;
                end else begin
                  cmd.clr_range = 1'b1;
                end
              end
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_SCAN_RD: begin
        if (flags.scan_more) begin
          cmd.slot_rd = 1'b1;
          cmd.rd_sel  = RD_IDX;
          state_next  = S_SCAN_CHK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN_CHK: begin
        if (flags.op == OP_ADD && flags.rd_empty) begin
          cmd.slot_wr = 1'b1;
          cmd.wr_sel  = WR_IDX_VAL;
          cmd.set_st  = 1'b1;
          cmd.st      = ST_OK;
          state_next  = S_FINISH;
        end else if (flags.op != OP_ADD && flags.rd_match) begin
          cmd.slot_clr = 1'b1;
          cmd.set_st   = 1'b1;
          cmd.st       = ST_OK;
          state_next   = S_FINISH;
        end else begin
          cmd.idx_sel = IDX_INC;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (flags.shift_in) begin
          cmd.slot_rd = 1'b1;
          cmd.rd_sel  = RD_UP;
          state_next  = S_SHIFT_WR;
        end else begin
          cmd.slot_clr = 1'b1;
          if (flags.last) begin
            state_next = S_FINISH;
          end else begin
            cmd.idx_sel = IDX_INC;
          end
        end
      end
      S_SHIFT_WR: begin
        cmd.slot_wr = 1'b1;
        cmd.wr_sel  = WR_IDX_RD;
        if (flags.last) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_sel = IDX_INC;
          state_next  = S_SHIFT_RD;
        end
      end
      S_GROW_RD: begin
        if (flags.grow_more) begin
          cmd.slot_rd = 1'b1;
          cmd.rd_sel  = RD_DOWN;
          state_next  = S_GROW_WR;
        end else begin
          cmd.clr_range = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_GROW_WR: begin
        cmd.slot_wr = 1'b1;
        cmd.wr_sel  = WR_IDX_RD;
        cmd.idx_sel = IDX_DEC;
        state_next  = S_GROW_RD;
      end
      S_FINISH: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/segmented_store_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_store_manager_top
// Flat slot memory split into contiguous stores, one operation per word.
// ----------------------------------------------------------------------------
// Each input word is one operation and gives exactly one result word. Work is
// one operation at a time: in_stall is high from acceptance until the result
// is loaded into the output register, which then waits for the consumer while
// the next word can already be taken. Create and unknown ids go from the check
// straight to the result; other operations first walk the store sizes to find
// the base, then scans read each slot touched, and compaction or growth shifts
// follow each registered read of the slot memory with the write.
// Reset clears the slot valid bits at once; no clearing pass is needed.
module segmented_store_manager_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssm_pkg::ssm_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output ssm_pkg::ssm_out_t out_word
);
  import ssm_pkg::*;

  // command and status between controller and datapath
  ssm_cmd_t   cmd;
  ssm_flags_t flags;

  // sequence the operation
  ssm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  // hold memories, counters and the result register
  ssm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .flags     (flags),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// File: src/ssm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the segmented store manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "segmented_store_manager_top_assert.svh"

module ssm_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ssm_pkg::ssm_out_t out_word
);
  import ssm_pkg::*;

  `SSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `SSM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SSM_ASSERT_SAME(a_free_bound, out_valid, out_word.free_slots <= 7'(SLOTS))
  `SSM_ASSERT_SAME(a_status_code, out_valid, out_word.status <= ST_UNKNOWN)
  `SSM_ASSERT_SAME(a_id_only_ok, out_valid && out_word.status != ST_OK, out_word.result_store_id == '0)

endmodule

bind segmented_store_manager_top ssm_checker u_ssm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
